FILE: src/ltcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltcc_pkg: shared types and constants for the log template cluster counter
// Sizes, status codes, controller states and controller/datapath bundles.
// ----------------------------------------------------------------------------
package ltcc_pkg;

  localparam int MaxEntries    = 32;
  localparam int TemplateBytes = 160;
  localparam int HitBits       = 32;
  localparam int FillLimit     = TemplateBytes - 4;
  localparam int IdxW          = $clog2(MaxEntries);
  localparam int CntW          = $clog2(MaxEntries + 1);
  localparam int PosW          = $clog2(TemplateBytes);
  localparam int LenW          = $clog2(TemplateBytes + 1);
  localparam int AddrW         = IdxW + PosW;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChGt    = 8'h3E;

  localparam logic [1:0] StMatch = 2'd0;
  localparam logic [1:0] StNew   = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_PUT, S_SCAN, S_CMP, S_CMPW, S_HIT, S_COPY, S_COPYW, S_NEW, S_SCANW
  } ltcc_state_t;

  typedef struct packed {
    logic       put_start;    // latch byte, begin writing
    logic       put_step;     // write one template byte
    logic       eol_clear;    // clear pending line
    logic       scan_init;    // entry index to 0
    logic       cmp_init;     // position to 0, match flag high
    logic       cmp_rd;       // issue read of stored/pending
    logic       cmp_chk;      // compare registered read data
    logic       next_entry;
    logic       copy_rd;
    logic       copy_wr;
    logic       do_hit;
    logic       do_new;
    logic       do_full;
  } ltcc_cmd_t;

  typedef struct packed {
    logic put_more;     // more template bytes to write
    logic entry_left;   // scan index below used entries
    logic len_eq;       // lengths equal
    logic cmp_more;     // position below pending length
    logic cmp_ok;       // match flag
    logic table_full;
    logic copy_more;
  } ltcc_stat_t;

endpackage
`default_nettype wire

FILE: src/ltcc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltcc_ctrl: controller
// Sequences byte intake, table scan, compare, copy and result hand-off.
// ----------------------------------------------------------------------------
module ltcc_ctrl
  import ltcc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_end_of_line,
  output logic            in_stall,
  input  wire logic       res_busy,
  input  wire ltcc_stat_t st,
  output ltcc_cmd_t       cmd
);

  ltcc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_end_of_line) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCANW;
          end else begin
            cmd.put_start = 1'b1;
            state_nxt     = S_PUT;
          end
        end
      end
      S_PUT: begin
        if (st.put_more) cmd.put_step = 1'b1;
        else             state_nxt = S_IDLE;
      end
      // entry row read settles
      S_SCANW: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (!st.entry_left) begin
          if (st.table_full) begin
            if (!res_busy) begin
              cmd.do_full = 1'b1; cmd.eol_clear = 1'b1; state_nxt = S_IDLE;
            end
          end else begin
            cmd.cmp_init = 1'b1; state_nxt = S_COPY;
          end
        end else if (!st.len_eq) begin
          cmd.next_entry = 1'b1; state_nxt = S_SCANW;
        end else begin
          cmd.cmp_init = 1'b1; state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (!st.cmp_ok) begin
          cmd.next_entry = 1'b1; state_nxt = S_SCANW;
        end else if (!st.cmp_more) begin
          state_nxt = S_HIT;
        end else begin
          cmd.cmp_rd = 1'b1; state_nxt = S_CMPW;
        end
      end
      S_CMPW: begin
        cmd.cmp_chk = 1'b1; state_nxt = S_CMP;
      end
      S_HIT: begin
        if (!res_busy) begin
          cmd.do_hit = 1'b1; cmd.eol_clear = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_COPY: begin
        if (st.copy_more) begin
          cmd.copy_rd = 1'b1; state_nxt = S_COPYW;
        end else begin
          state_nxt = S_NEW;
        end
      end
      S_COPYW: begin
        cmd.copy_wr = 1'b1; state_nxt = S_COPY;
      end
      S_NEW: begin
        if (!res_busy) begin
          cmd.do_new = 1'b1; cmd.eol_clear = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/ltcc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltcc_dp: datapath
// Pending template buffer, template memory, length/count tables, top tracker.
// ----------------------------------------------------------------------------
module ltcc_dp
  import ltcc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [7:0]          in_line_byte,
  input  wire ltcc_cmd_t           cmd,
  output ltcc_stat_t               st,
  input  wire logic                out_stall,
  output logic                     res_busy,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [4:0]               out_entry_index,
  output logic [31:0]              out_entry_hits,
  output logic [5:0]               out_entries_used,
  output logic                     out_top_valid,
  output logic [4:0]               out_top_index,
  output logic [31:0]              out_top_hits
);

  localparam logic [HitBits-1:0] HitMax = '1;

  logic [7:0]         pend_mem [TemplateBytes];
  logic [7:0]         text_mem [MaxEntries*TemplateBytes];
  logic [LenW-1:0]    len_mem  [MaxEntries];
  logic [HitBits-1:0] hits_mem [MaxEntries];

  logic [LenW-1:0]    plen_r;
  logic               run_r;
  logic [7:0]         pbyte_r [3];
  logic [1:0]         pcnt_r, pidx_r;
  logic [CntW-1:0]    used_r;
  logic [IdxW-1:0]    best_idx_r;
  logic [HitBits-1:0] best_hits_r;
  logic [CntW-1:0]    eidx_r;
  logic [LenW-1:0]    pos_r;
  logic               ok_r;
  logic [7:0]         prd_r, trd_r;
  logic [LenW-1:0]    elen_r;
  logic [HitBits-1:0] ehits_r;
  logic               ov_r;

  logic               digit;
  logic [IdxW-1:0]    eix;
  logic [HitBits-1:0] inc_hits;
  logic [AddrW-1:0]   taddr;

  assign digit    = (in_line_byte >= ChZero) && (in_line_byte <= ChNine);
  assign eix      = eidx_r[IdxW-1:0];
  assign taddr    = AddrW'(eix) * AddrW'(TemplateBytes) + AddrW'(pos_r);
  assign inc_hits = (ehits_r == HitMax) ? ehits_r : ehits_r + 1'b1;

  assign st.put_more   = pidx_r != pcnt_r;
  assign st.entry_left = eidx_r < used_r;
  assign st.len_eq     = elen_r == plen_r;
  assign st.cmp_more   = pos_r < plen_r;
  assign st.cmp_ok     = ok_r;
  assign st.table_full = used_r == CntW'(MaxEntries);
  assign st.copy_more  = pos_r < plen_r;
  assign res_busy      = ov_r && out_stall;

  // table row reads are registered; index follows eidx_r
  always_ff @(posedge clk) begin
    elen_r  <= len_mem[eix];
    ehits_r <= hits_mem[eix];
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_rd || cmd.copy_rd) begin
      prd_r <= pend_mem[pos_r[PosW-1:0]];
      trd_r <= text_mem[taddr];
    end
    if (cmd.put_step)
      pend_mem[plen_r[PosW-1:0]] <= pbyte_r[pidx_r];
    if (cmd.copy_wr)
      text_mem[taddr - AddrW'(1)] <= prd_r;
    if (cmd.do_new) begin
      len_mem[eix]  <= plen_r;
      hits_mem[eix] <= HitBits'(1);
    end
    if (cmd.do_hit)
      hits_mem[eix] <= inc_hits;
    if (cmd.put_start) begin
      pbyte_r[0] <= digit ? ChLt : in_line_byte;
      pbyte_r[1] <= ChStar;
      pbyte_r[2] <= ChGt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0; run_r <= 1'b0; pcnt_r <= '0; pidx_r <= '0;
      used_r <= '0; best_idx_r <= '0; best_hits_r <= '0;
      eidx_r <= '0; pos_r <= '0; ok_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (cmd.put_start) begin
        pidx_r <= '0;
        if (plen_r >= LenW'(FillLimit))     pcnt_r <= 2'd0;
        else if (!digit)                    pcnt_r <= 2'd1;
        else if (!run_r)                    pcnt_r <= 2'd3;
        else                                pcnt_r <= 2'd0;
        if (plen_r < LenW'(FillLimit)) run_r <= digit;
      end
      if (cmd.put_step) begin
        pidx_r <= pidx_r + 2'd1;
        plen_r <= plen_r + 1'b1;
      end
      if (cmd.scan_init) eidx_r <= '0;
      if (cmd.next_entry) eidx_r <= eidx_r + 1'b1;
      if (cmd.cmp_init) begin pos_r <= '0; ok_r <= 1'b1; end
      if (cmd.cmp_rd || cmd.copy_rd) pos_r <= pos_r + 1'b1;
      if (cmd.cmp_chk && prd_r != trd_r) ok_r <= 1'b0;
      if (cmd.eol_clear) begin plen_r <= '0; run_r <= 1'b0; end
      if (cmd.do_hit || cmd.do_new || cmd.do_full) ov_r <= 1'b1;
      if (cmd.do_hit) begin
        if (inc_hits > best_hits_r || (inc_hits == best_hits_r && eix < best_idx_r)) begin
          best_hits_r <= inc_hits; best_idx_r <= eix;
        end
      end
      if (cmd.do_new) begin
        used_r <= used_r + 1'b1;
        if (HitBits'(1) > best_hits_r ||
            (HitBits'(1) == best_hits_r && eix < best_idx_r)) begin
          best_hits_r <= HitBits'(1); best_idx_r <= eix;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.do_hit || cmd.do_new || cmd.do_full) begin
      out_status      <= cmd.do_hit ? StMatch : (cmd.do_new ? StNew : StFull);
      out_entry_index <= cmd.do_full ? 5'd0 : 5'(eix);
      out_entry_hits  <= cmd.do_full ? 32'd0 :
                         (cmd.do_new ? 32'd1 : 32'(inc_hits));
    end
  end

  // top fields follow the live state, which holds until the next line ends
  assign out_valid        = ov_r;
  assign out_entries_used = 6'(used_r);
  assign out_top_valid    = used_r != '0;
  assign out_top_index    = (used_r != '0) ? 5'(best_idx_r) : 5'd0;
  assign out_top_hits     = (used_r != '0) ? 32'(best_hits_r) : 32'd0;

endmodule
`default_nettype wire

FILE: src/log_template_cluster_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// log_template_cluster_counter: log template clustering counter
// Builds a digit-masked template per line and counts matching templates.
//
//  channel | dir | ports
//  in      | in  | in_valid, in_stall, in_line_byte, in_end_of_line
//  out     | out | out_valid, out_stall, status/index/hits/used/top fields
//
// A data byte writes zero, one or three template bytes (one template byte write per cycle).
// End of line scans the entries in turn, compares byte by byte, and copies
// the template byte by byte into a new entry.
// Synchronous active-low reset clears control state; no clearing pass.
// A stalled result holds; the next result waits until it is taken.
// ----------------------------------------------------------------------------
module log_template_cluster_counter
  import ltcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_line_byte,
  input  wire logic        in_end_of_line,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [4:0]       out_entry_index,
  output logic [31:0]      out_entry_hits,
  output logic [5:0]       out_entries_used,
  output logic             out_top_valid,
  output logic [4:0]       out_top_index,
  output logic [31:0]      out_top_hits
);

  ltcc_cmd_t  cmd;
  ltcc_stat_t st;
  logic       res_busy;

  ltcc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_end_of_line, .in_stall,
    .res_busy, .st, .cmd
  );

  ltcc_dp u_dp (
    .clk, .rst_n, .in_line_byte, .cmd, .st, .out_stall, .res_busy,
    .out_valid, .out_status, .out_entry_index, .out_entry_hits,
    .out_entries_used, .out_top_valid, .out_top_index, .out_top_hits
  );

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_entries_used <= 6'(MaxEntries)) else $error("entry count overflow");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == StFull) |-> out_entry_hits == 32'd0)
    else $error("full result carries hits");

endmodule
`default_nettype wire

FILE: verif/log_template_cluster_counter_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_template_cluster_counter_chk: prediction and checking of results
// Follows every accepted input beat, builds the digit-masked template and
// the template table itself, and compares each result beat field by field.
// ----------------------------------------------------------------------------
module log_template_cluster_counter_chk
  import ltcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_line_byte,
  input  logic        in_end_of_line,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [4:0]  out_entry_index,
  input  logic [31:0] out_entry_hits,
  input  logic [5:0]  out_entries_used,
  input  logic        out_top_valid,
  input  logic [4:0]  out_top_index,
  input  logic [31:0] out_top_hits,
  output int          fail_count,
  output int          pending_results,
  output int          results_seen
);

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  index;
    logic [31:0] hits;
    logic [5:0]  used;
    logic        top_valid;
    logic [4:0]  top_index;
    logic [31:0] top_hits;
  } lookup_result_t;

  lookup_result_t lookup_q[$];

  logic [7:0]  line_tpl[TemplateBytes];
  int          line_len;
  bit          in_digits;
  logic [7:0]  table_tpl[MaxEntries][TemplateBytes];
  int          table_len[MaxEntries];
  logic [31:0] table_hits[MaxEntries];
  int          table_used;
  int          best_idx;
  logic [31:0] best_cnt;

  assign pending_results = lookup_q.size();

  function automatic void add_byte(logic [7:0] b);
    if (line_len >= FillLimit) return;
    if (b >= ChZero && b <= ChNine) begin
      if (!in_digits) begin
        line_tpl[line_len] = ChLt;
        line_tpl[line_len + 1] = ChStar;
        line_tpl[line_len + 2] = ChGt;
        line_len += 3;
        in_digits = 1;
      end
    end else begin
      in_digits = 0;
      line_tpl[line_len] = b;
      line_len += 1;
    end
  endfunction

  function automatic void note_best(int idx, logic [31:0] cnt);
    if (cnt > best_cnt || (cnt == best_cnt && idx < best_idx)) begin
      best_cnt = cnt;
      best_idx = idx;
    end
  endfunction

  function automatic lookup_result_t close_line();
    lookup_result_t r;
    int hit;
    bit same;
    hit = -1;
    r = '0;
    for (int e = 0; e < table_used && hit < 0; e++) begin
      same = (table_len[e] == line_len);
      for (int p = 0; same && p < line_len; p++)
        if (table_tpl[e][p] != line_tpl[p]) same = 0;
      if (same) hit = e;
    end
    if (hit >= 0) begin
      if (table_hits[hit] != 32'hFFFF_FFFF) table_hits[hit] += 1;
      note_best(hit, table_hits[hit]);
      r.status = StMatch;
      r.index = hit[4:0];
      r.hits = table_hits[hit];
    end else if (table_used >= MaxEntries) begin
      r.status = StFull;
    end else begin
      for (int p = 0; p < line_len; p++) table_tpl[table_used][p] = line_tpl[p];
      table_len[table_used] = line_len;
      table_hits[table_used] = 1;
      note_best(table_used, 1);
      r.status = StNew;
      r.index = table_used[4:0];
      r.hits = 1;
      table_used += 1;
    end
    line_len = 0;
    in_digits = 0;
    r.used = table_used[5:0];
    r.top_valid = (table_used > 0);
    r.top_index = (table_used > 0) ? best_idx[4:0] : '0;
    r.top_hits = (table_used > 0) ? best_cnt : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (!rst_n) begin
      line_len <= 0;
      in_digits <= 0;
      table_used <= 0;
      best_idx <= 0;
      best_cnt <= '0;
      fail_count <= 0;
      results_seen <= 0;
      lookup_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (in_end_of_line) lookup_q.push_back(close_line());
        else add_byte(in_line_byte);
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (lookup_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = lookup_q.pop_front();
          if (out_status !== exp_r.status ||
              out_entry_index !== exp_r.index ||
              out_entry_hits !== exp_r.hits ||
              out_entries_used !== exp_r.used ||
              out_top_valid !== exp_r.top_valid ||
              out_top_index !== exp_r.top_index ||
              out_top_hits !== exp_r.top_hits)
            fail_count <= fail_count + 1;
          if (out_status !== exp_r.status)
            $error("status exp %0d got %0d", exp_r.status, out_status);
          if (out_entry_index !== exp_r.index)
            $error("entry_index exp %0d got %0d", exp_r.index, out_entry_index);
          if (out_entry_hits !== exp_r.hits)
            $error("entry_hits exp %0d got %0d", exp_r.hits, out_entry_hits);
          if (out_entries_used !== exp_r.used)
            $error("entries_used exp %0d got %0d", exp_r.used, out_entries_used);
          if (out_top_valid !== exp_r.top_valid)
            $error("top_valid exp %0d got %0d", exp_r.top_valid, out_top_valid);
          if (out_top_index !== exp_r.top_index)
            $error("top_index exp %0d got %0d", exp_r.top_index, out_top_index);
          if (out_top_hits !== exp_r.top_hits)
            $error("top_hits exp %0d got %0d", exp_r.top_hits, out_top_hits);
        end
      end
    end
  end

endmodule

FILE: verif/log_template_cluster_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_template_cluster_counter_tb: top level of the template counter bench
// Sends directed lines (empty, digit runs, overlong, zero bytes), random lines
// from a small template vocabulary, then a table overflow, with bursty
// input and a stall pattern on the result side; the checker judges results.
// ----------------------------------------------------------------------------
module log_template_cluster_counter_tb;
  import ltcc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_line_byte;
  logic        in_end_of_line;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [4:0]  out_entry_index;
  logic [31:0] out_entry_hits;
  logic [5:0]  out_entries_used;
  logic        out_top_valid;
  logic [4:0]  out_top_index;
  logic [31:0] out_top_hits;
  int          fail_count;
  int          pending_results;
  int          results_seen;
  int          beats_sent;

  log_template_cluster_counter DUT (.*);

  log_template_cluster_counter_chk checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // result-side stall pattern: randomly chosen modes, including no stall
  initial begin
    int mode;
    out_stall = 0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 120)) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  int burst_left;

  task automatic send_beat(logic [7:0] b, logic eol);
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1;
    in_line_byte <= b;
    in_end_of_line <= eol;
    do @(posedge clk); while (in_stall);
    burst_left--;
    beats_sent++;
  endtask

  task automatic send_line(string s);
    for (int k = 0; k < s.len(); k++) send_beat(s[k], 0);
    send_beat(8'($urandom_range(0, 255)), 1);
  endtask

  task automatic send_random_line(int tag);
    int n;
    n = $urandom_range(0, 12);
    send_beat("t", 0);
    send_beat(8'h61 + tag[7:0], 0);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 1)) send_beat(8'($urandom_range(ChZero, ChNine)), 0);
      else send_beat(" ", 0);
    end
    send_beat(8'($urandom_range(0, 255)), 1);
  endtask

  initial begin
    string s;
    rst_n = 0;
    in_valid = 0;
    in_line_byte = 0;
    in_end_of_line = 0;
    beats_sent = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_line("");
    send_line("");
    send_line("a0123b9");
    send_line("a7b1");
    send_beat(8'h00, 0);
    send_beat(8'hFF, 0);
    send_beat(8'hAA, 0);
    send_beat(8'h55, 0);
    send_beat(8'h00, 1);
    s = "";
    for (int k = 0; k < 80; k++) begin
      if (k % 2) s = {s, "x"};
      else s = {s, "5"};
    end
    send_line(s);
    s = "";
    for (int k = 0; k < 160; k++) s = {s, "y"};
    send_line(s);
    send_line(s);
    // random part: most lines from a small vocabulary, some unique to fill
    while (beats_sent < 540) begin
      if ($urandom_range(0, 9) == 0) send_random_line($urandom_range(0, 60));
      else send_random_line($urandom_range(0, 5));
    end
    // overflow the table
    for (int k = 0; k < 34; k++) send_line({"q", string'(8'h40 + k[7:0])});
    send_line("a7b1");
    in_valid <= 0;
    while (pending_results != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    $display("Sent %0d input beats, checked %0d lookup results.", beats_sent,
             results_seen);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
